[hdl/psjq_pkg.sv]
package psjq_pkg;

  localparam int QDEPTH  = 5;
  localparam int PRIO_W  = 8;
  localparam int PAY_W   = 32;
  localparam int RETRY_W = 8;
  localparam int CNT_W   = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_RETRY = 2'd2,
    ACT_QUERY = 2'd3
  } psjq_act_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } psjq_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } psjq_cmd_t;

endpackage

[hdl/priority_sorted_job_queue.sv]
// Channel   Ports                                   Direction
// in        in_valid/in_ready, action, job fields   beat into the queue
// out       out_valid/out_ready, head report        beat out of the queue
//
// A beat is first captured and its priority compared against all five
// slots at once; then the sorted slots shift and the result register is
// loaded. A new beat is taken in the cycle after the commit.
// Reset clears the job count and the handshake state; slot contents are
// left as they are. A stalled result holds the commit until out_ready.
module priority_sorted_job_queue
  import psjq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_job_priority,
  input  logic [7:0]  in_job_retry,
  input  logic [31:0] in_job_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_head_valid,
  output logic [7:0]  out_head_priority,
  output logic [7:0]  out_head_retry,
  output logic [31:0] out_head_payload,
  output logic [2:0]  out_occupancy,
  output logic        out_is_full
);

  psjq_cmd_t cmd;

  psjq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  psjq_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_action         (in_action),
    .in_job_priority   (in_job_priority),
    .in_job_retry      (in_job_retry),
    .in_job_payload    (in_job_payload),
    .out_accepted      (out_accepted),
    .out_head_valid    (out_head_valid),
    .out_head_priority (out_head_priority),
    .out_head_retry    (out_head_retry),
    .out_head_payload  (out_head_payload),
    .out_occupancy     (out_occupancy),
    .out_is_full       (out_is_full)
  );

endmodule

[hdl/psjq_ctrl.sv]
module psjq_ctrl
  import psjq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output psjq_cmd_t cmd
);

  psjq_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/psjq_dpath.sv]
module psjq_dpath
  import psjq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  psjq_cmd_t   cmd,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_job_priority,
  input  logic [7:0]  in_job_retry,
  input  logic [31:0] in_job_payload,
  output logic        out_accepted,
  output logic        out_head_valid,
  output logic [7:0]  out_head_priority,
  output logic [7:0]  out_head_retry,
  output logic [31:0] out_head_payload,
  output logic [2:0]  out_occupancy,
  output logic        out_is_full
);

  logic [PRIO_W-1:0]  slot_prio_r  [QDEPTH];
  logic [RETRY_W-1:0] slot_retry_r [QDEPTH];
  logic [PAY_W-1:0]   slot_pay_r   [QDEPTH];
  logic [PRIO_W-1:0]  slot_prio_nxt  [QDEPTH];
  logic [RETRY_W-1:0] slot_retry_nxt [QDEPTH];
  logic [PAY_W-1:0]   slot_pay_nxt   [QDEPTH];
  logic [CNT_W-1:0]   count_r, count_nxt;

  psjq_act_t          req_act_r;
  logic [PRIO_W-1:0]  req_prio_r;
  logic [RETRY_W-1:0] req_retry_r;
  logic [PAY_W-1:0]   req_pay_r;
  logic [QDEPTH-1:0]  le_r, le_nxt;

  logic [PRIO_W-1:0]  in_prio;
  logic               ok;

  logic               acc_r;
  logic               hv_r;
  logic [7:0]         hprio_r;
  logic [7:0]         hretry_r;
  logic [31:0]        hpay_r;
  logic [2:0]         occ_r;
  logic               full_r;

  assign in_prio = PRIO_W'(in_job_priority);

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      le_nxt[i] = (CNT_W'(i) < count_r) && (slot_prio_r[i] <= in_prio);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_act_r   <= psjq_act_t'(in_action);
      req_prio_r  <= in_prio;
      req_retry_r <= RETRY_W'(in_job_retry);
      req_pay_r   <= PAY_W'(in_job_payload);
      le_r        <= le_nxt;
    end
  end

  always_comb begin
    slot_prio_nxt  = slot_prio_r;
    slot_retry_nxt = slot_retry_r;
    slot_pay_nxt   = slot_pay_r;
    count_nxt      = count_r;
    ok             = 1'b1;
    case (req_act_r)
      ACT_PUSH: begin
        if (count_r == CNT_W'(QDEPTH)) begin
          ok = 1'b0;
        end else begin
          count_nxt = count_r + 1'b1;
          if (!le_r[0]) begin
            slot_prio_nxt[0]  = req_prio_r;
            slot_retry_nxt[0] = req_retry_r;
            slot_pay_nxt[0]   = req_pay_r;
          end
          for (int i = 1; i < QDEPTH; i++) begin
            if (!le_r[i]) begin
              if (le_r[i-1]) begin
                slot_prio_nxt[i]  = req_prio_r;
                slot_retry_nxt[i] = req_retry_r;
                slot_pay_nxt[i]   = req_pay_r;
              end else begin
                slot_prio_nxt[i]  = slot_prio_r[i-1];
                slot_retry_nxt[i] = slot_retry_r[i-1];
                slot_pay_nxt[i]   = slot_pay_r[i-1];
              end
            end
          end
        end
      end
      ACT_POP: begin
        if (count_r == '0) begin
          ok = 1'b0;
        end else begin
          count_nxt = count_r - 1'b1;
          for (int i = 0; i < QDEPTH - 1; i++) begin
            slot_prio_nxt[i]  = slot_prio_r[i+1];
            slot_retry_nxt[i] = slot_retry_r[i+1];
            slot_pay_nxt[i]   = slot_pay_r[i+1];
          end
        end
      end
      ACT_RETRY: begin
        if (count_r != '0) begin
          slot_retry_nxt[0] = req_retry_r;
        end
      end
      ACT_QUERY: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_prio_r  <= slot_prio_nxt;
      slot_retry_r <= slot_retry_nxt;
      slot_pay_r   <= slot_pay_nxt;
      acc_r        <= ok;
      hv_r         <= (count_nxt != '0);
      hprio_r      <= (count_nxt != '0) ? 8'(slot_prio_nxt[0]) : 8'd0;
      hretry_r     <= (count_nxt != '0) ? 8'(slot_retry_nxt[0]) : 8'd0;
      hpay_r       <= (count_nxt != '0) ? 32'(slot_pay_nxt[0]) : 32'd0;
      occ_r        <= 3'(count_nxt);
      full_r       <= (count_nxt == CNT_W'(QDEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  assign out_accepted      = acc_r;
  assign out_head_valid    = hv_r;
  assign out_head_priority = hprio_r;
  assign out_head_retry    = hretry_r;
  assign out_head_payload  = hpay_r;
  assign out_occupancy     = occ_r;
  assign out_is_full       = full_r;

endmodule

[hdl/psjq_chk.sv]
module psjq_chk
  import psjq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_head_valid,
  input logic [7:0]  out_head_priority,
  input logic [7:0]  out_head_retry,
  input logic [31:0] out_head_payload,
  input logic [2:0]  out_occupancy,
  input logic        out_is_full
);

  a_head_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == (out_occupancy != 3'd0)))
    else $error("head valid disagrees with occupancy");

  a_full_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_full == (out_occupancy == 3'(QDEPTH))))
    else $error("full flag disagrees with occupancy");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_head_valid) |->
      (out_head_priority == 8'd0 && out_head_retry == 8'd0 &&
       out_head_payload == 32'd0))
    else $error("empty queue reports a head job");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a beat is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_occupancy) && $stable(out_head_payload)))
    else $error("stalled result changed");

endmodule

bind priority_sorted_job_queue psjq_chk u_psjq_chk (.*);
